FILE: design/pbd_pkg.sv
// shared types, register indexes and small arithmetic helpers of the price bar downsampler
package pbd_pkg;

    typedef enum logic [1:0] {
        MODE_CLOSE    = 2'd0,
        MODE_MIDPOINT = 2'd1,
        MODE_TYPICAL  = 2'd2,
        MODE_AVERAGE  = 2'd3
    } t_bar_mode;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_GROUP_SIZE = 1'd0;
    localparam t_cfg_index CFG_BAR_MODE   = 1'd1;

    // residue of one base-4 digit modulo 3
    function automatic logic [1:0] f_digit_mod3(input logic [1:0] d);
        logic [1:0] r;
        r = (d == 2'd3) ? 2'd0 : d;
        return r;
    endfunction

    // sum of two residues modulo 3
    function automatic logic [1:0] f_mod3_add(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

    // quotient digit of (4 * remainder + digit) / 3, remainder in 0..2
    function automatic logic [1:0] f_quot_digit(input logic [1:0] rem, input logic [1:0] d);
        logic [1:0] q;
        case ({rem, d})
            4'b00_00: q = 2'd0;
            4'b00_01: q = 2'd0;
            4'b00_10: q = 2'd0;
            4'b00_11: q = 2'd1;
            4'b01_00: q = 2'd1;
            4'b01_01: q = 2'd1;
            4'b01_10: q = 2'd2;
            4'b01_11: q = 2'd2;
            4'b10_00: q = 2'd2;
            4'b10_01: q = 2'd3;
            4'b10_10: q = 2'd3;
            4'b10_11: q = 2'd3;
            default:  q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

FILE: design/pbd_div3.sv
// unsigned divide by three: base-4 long division with a prefix tree for the remainders
module pbd_div3 #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] i_dividend,
    output logic [WIDTH-1:0] o_quotient
);
    import pbd_pkg::*;

    localparam int ND = (WIDTH + 1) / 2;
    localparam int LV = $clog2(ND);

    logic [2*ND-1:0] padded;
    logic [2*ND-1:0] quot;
    logic [1:0]      pre [LV+1][ND];

    assign padded = (2*ND)'(i_dividend);

    // residue of (x >> 2j) for every digit j, built as a suffix sum mod 3
    for (genvar j = 0; j < ND; j++) begin : g_leaf
        assign pre[0][j] = f_digit_mod3(padded[2*j +: 2]);
    end

    for (genvar l = 0; l < LV; l++) begin : g_level
        for (genvar j = 0; j < ND; j++) begin : g_node
            if (j + (1 << l) < ND) begin : g_join
                assign pre[l+1][j] = f_mod3_add(pre[l][j], pre[l][j + (1 << l)]);
            end else begin : g_pass
                assign pre[l+1][j] = pre[l][j];
            end
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_digit
        if (j == ND - 1) begin : g_top
            assign quot[2*j +: 2] = f_quot_digit(2'd0, padded[2*j +: 2]);
        end else begin : g_low
            assign quot[2*j +: 2] = f_quot_digit(pre[LV][j+1], padded[2*j +: 2]);
        end
    end

    assign o_quotient = quot[WIDTH-1:0];

endmodule

FILE: design/pbd_run_tracker.sv
// run state of the current bar: tick count, open, high and low, plus the bar term register
module pbd_run_tracker #(
    parameter int PRICE_WIDTH = 32,
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [COUNT_WIDTH-1:0]        i_group_size,
    input  pbd_pkg::t_bar_mode            i_bar_mode,
    input  logic                          i_tick_valid,
    output logic                          o_tick_ready,
    input  logic [TIME_WIDTH-1:0]         i_tick_time,
    input  logic signed [PRICE_WIDTH-1:0] i_tick_price,
    input  logic                          i_end_of_series,
    output logic                          o_terms_valid,
    input  logic                          i_terms_ready,
    output logic [TIME_WIDTH-1:0]         o_time,
    output logic signed [PRICE_WIDTH-1:0] o_high,
    output logic signed [PRICE_WIDTH-1:0] o_low,
    output logic signed [PRICE_WIDTH-1:0] o_close,
    output logic signed [PRICE_WIDTH-1:0] o_open,
    output pbd_pkg::t_bar_mode            o_mode
);
    import pbd_pkg::*;

    logic [COUNT_WIDTH-1:0]        r_run_position;
    logic signed [PRICE_WIDTH-1:0] r_run_open;
    logic signed [PRICE_WIDTH-1:0] r_run_high;
    logic signed [PRICE_WIDTH-1:0] r_run_low;
    logic                          r_terms_valid;

    logic                          accept;
    logic                          first_tick;
    logic                          emit;
    logic [COUNT_WIDTH-1:0]        n_run_position;
    logic signed [PRICE_WIDTH-1:0] n_run_open;
    logic signed [PRICE_WIDTH-1:0] n_run_high;
    logic signed [PRICE_WIDTH-1:0] n_run_low;

    assign o_tick_ready  = !r_terms_valid || i_terms_ready;
    assign accept        = i_tick_valid && o_tick_ready;
    assign o_terms_valid = r_terms_valid;

    always_comb begin
        first_tick     = (r_run_position == '0);
        n_run_position = r_run_position + COUNT_WIDTH'(1);
        n_run_open     = first_tick ? i_tick_price : r_run_open;
        n_run_high     = r_run_high;
        n_run_low      = r_run_low;
        if (first_tick || (i_tick_price > r_run_high)) begin
            n_run_high = i_tick_price;
        end
        if (first_tick || (i_tick_price < r_run_low)) begin
            n_run_low = i_tick_price;
        end
        // position wrap counts as a full run
        emit = (i_group_size != '0) &&
               (i_end_of_series || (n_run_position == '0) ||
                (n_run_position >= i_group_size));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_position <= '0;
        end else if (accept) begin
            if ((i_group_size == '0) || emit) begin
                r_run_position <= '0;
            end else begin
                r_run_position <= n_run_position;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_run_open <= n_run_open;
            r_run_high <= n_run_high;
            r_run_low  <= n_run_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terms_valid <= 1'b0;
        end else if (o_tick_ready) begin
            r_terms_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            o_time  <= i_tick_time;
            o_high  <= n_run_high;
            o_low   <= n_run_low;
            o_close <= i_tick_price;
            o_open  <= n_run_open;
            o_mode  <= i_bar_mode;
        end
    end

endmodule

FILE: design/pbd_bar_calc.sv
// bar value pipeline: mode sum, magnitude divide, sign restore into the result register
module pbd_bar_calc #(
    parameter int PRICE_WIDTH = 32,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_terms_valid,
    output logic                          o_terms_ready,
    input  logic [TIME_WIDTH-1:0]         i_time,
    input  logic signed [PRICE_WIDTH-1:0] i_high,
    input  logic signed [PRICE_WIDTH-1:0] i_low,
    input  logic signed [PRICE_WIDTH-1:0] i_close,
    input  logic signed [PRICE_WIDTH-1:0] i_open,
    input  pbd_pkg::t_bar_mode            i_mode,
    output logic                          o_bar_valid,
    input  logic                          i_bar_ready,
    output logic [TIME_WIDTH-1:0]         o_bar_time,
    output logic signed [PRICE_WIDTH-1:0] o_bar_price
);
    import pbd_pkg::*;

    localparam int SW = PRICE_WIDTH + 2;

    // sum stage
    logic                   r_b_valid;
    logic signed [SW-1:0]   r_b_sum;
    t_bar_mode              r_b_mode;
    logic [TIME_WIDTH-1:0]  r_b_time;
    // divide stage
    logic                   r_c_valid;
    logic [SW-1:0]          r_c_quot;
    logic                   r_c_neg;
    logic [TIME_WIDTH-1:0]  r_c_time;
    // result register
    logic                   r_d_valid;
    logic [TIME_WIDTH-1:0]  r_d_time;
    logic [PRICE_WIDTH-1:0] r_d_price;

    logic                   ready_b;
    logic                   ready_c;
    logic                   ready_d;

    logic signed [SW-1:0]   ext_high;
    logic signed [SW-1:0]   ext_low;
    logic signed [SW-1:0]   ext_close;
    logic signed [SW-1:0]   ext_open;
    logic signed [SW-1:0]   n_b_sum;
    logic                   sum_neg;
    logic [SW-1:0]          magnitude;
    logic [SW-1:0]          mag_div3;
    logic [SW-1:0]          n_c_quot;
    logic [SW-1:0]          n_d_full;

    assign ready_d       = !r_d_valid || i_bar_ready;
    assign ready_c       = !r_c_valid || ready_d;
    assign ready_b       = !r_b_valid || ready_c;
    assign o_terms_ready = ready_b;

    assign ext_high  = {{2{i_high[PRICE_WIDTH-1]}}, i_high};
    assign ext_low   = {{2{i_low[PRICE_WIDTH-1]}}, i_low};
    assign ext_close = {{2{i_close[PRICE_WIDTH-1]}}, i_close};
    assign ext_open  = {{2{i_open[PRICE_WIDTH-1]}}, i_open};

    always_comb begin
        case (i_mode)
            MODE_MIDPOINT: n_b_sum = ext_high + ext_low;
            MODE_TYPICAL:  n_b_sum = (ext_high + ext_low) + ext_close;
            MODE_AVERAGE:  n_b_sum = (ext_high + ext_low) + (ext_close + ext_open);
            default:       n_b_sum = ext_close;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= i_terms_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_terms_valid) begin
            r_b_sum  <= n_b_sum;
            r_b_mode <= i_mode;
            r_b_time <= i_time;
        end
    end

    // truncation toward zero: divide the magnitude, restore the sign afterwards
    assign sum_neg   = r_b_sum[SW-1];
    assign magnitude = sum_neg ? (SW'(0) - r_b_sum) : r_b_sum;

    pbd_div3 #(
        .WIDTH(SW)
    ) u_div3 (
        .i_dividend(magnitude),
        .o_quotient(mag_div3)
    );

    always_comb begin
        case (r_b_mode)
            MODE_MIDPOINT: n_c_quot = magnitude >> 1;
            MODE_TYPICAL:  n_c_quot = mag_div3;
            MODE_AVERAGE:  n_c_quot = magnitude >> 2;
            default:       n_c_quot = magnitude;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_c_quot <= n_c_quot;
            r_c_neg  <= sum_neg;
            r_c_time <= r_b_time;
        end
    end

    assign n_d_full = r_c_neg ? (SW'(0) - r_c_quot) : r_c_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (ready_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_d && r_c_valid) begin
            r_d_time  <= r_c_time;
            r_d_price <= n_d_full[PRICE_WIDTH-1:0];
        end
    end

    assign o_bar_valid = r_d_valid;
    assign o_bar_time  = r_d_time;
    assign o_bar_price = signed'(r_d_price);

endmodule

FILE: design/price_bar_downsampler.sv
// top level of the price bar downsampler: configuration registers, run tracker and bar pipeline
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  tick in  | i_tick_valid / o_tick_ready    | i_tick_time, i_tick_price, i_end_of_series
//  bar out  | o_bar_valid  / i_bar_ready     | o_bar_time, o_bar_price
//  config   | i_cfg_we (no wait, no readback) | i_cfg_index, i_cfg_data
//
//  one tick transaction per cycle while o_tick_ready is high; after the transaction of the tick that
//  closes its run, a bar passes in order through the term, sum, divide and result registers
//  the run state (count, open, high, low) is updated in the cycle of the tick transaction,
//  so a tick may follow in the very next cycle
//  synchronous active-low reset empties the pipeline and the run, group_size = 1, mode = close
//  a stalled output only holds back the stages behind it once they are all full

module price_bar_downsampler #(
    parameter int PRICE_WIDTH = 32,
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  pbd_pkg::t_cfg_index           i_cfg_index,
    input  logic [COUNT_WIDTH-1:0]        i_cfg_data,
    // tick input
    input  logic                          i_tick_valid,
    output logic                          o_tick_ready,
    input  logic [TIME_WIDTH-1:0]         i_tick_time,
    input  logic signed [PRICE_WIDTH-1:0] i_tick_price,
    input  logic                          i_end_of_series,
    // bar output
    output logic                          o_bar_valid,
    input  logic                          i_bar_ready,
    output logic [TIME_WIDTH-1:0]         o_bar_time,
    output logic signed [PRICE_WIDTH-1:0] o_bar_price
);
    import pbd_pkg::*;

    logic [COUNT_WIDTH-1:0]        r_group_size;
    t_bar_mode                     r_bar_mode;

    // finished bar terms between tracker and value pipeline
    logic                          terms_valid;
    logic                          terms_ready;
    logic [TIME_WIDTH-1:0]         terms_time;
    logic signed [PRICE_WIDTH-1:0] terms_high;
    logic signed [PRICE_WIDTH-1:0] terms_low;
    logic signed [PRICE_WIDTH-1:0] terms_close;
    logic signed [PRICE_WIDTH-1:0] terms_open;
    t_bar_mode                     terms_mode;

    // configuration decode; to be written only while the block is idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= COUNT_WIDTH'(1);
            r_bar_mode   <= MODE_CLOSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GROUP_SIZE: r_group_size <= i_cfg_data;
                CFG_BAR_MODE:   r_bar_mode   <= t_bar_mode'(i_cfg_data[1:0]);
                default:        r_bar_mode   <= r_bar_mode;
            endcase
        end
    end

    // run bookkeeping; a closing tick hands its terms on and restarts the run
    pbd_run_tracker #(
        .PRICE_WIDTH(PRICE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_group_size   (r_group_size),
        .i_bar_mode     (r_bar_mode),
        .i_tick_valid   (i_tick_valid),
        .o_tick_ready   (o_tick_ready),
        .i_tick_time    (i_tick_time),
        .i_tick_price   (i_tick_price),
        .i_end_of_series(i_end_of_series),
        .o_terms_valid  (terms_valid),
        .i_terms_ready  (terms_ready),
        .o_time         (terms_time),
        .o_high         (terms_high),
        .o_low          (terms_low),
        .o_close        (terms_close),
        .o_open         (terms_open),
        .o_mode         (terms_mode)
    );

    // mode-selected average, truncated toward zero
    pbd_bar_calc #(
        .PRICE_WIDTH(PRICE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_terms_valid(terms_valid),
        .o_terms_ready(terms_ready),
        .i_time       (terms_time),
        .i_high       (terms_high),
        .i_low        (terms_low),
        .i_close      (terms_close),
        .i_open       (terms_open),
        .i_mode       (terms_mode),
        .o_bar_valid  (o_bar_valid),
        .i_bar_ready  (i_bar_ready),
        .o_bar_time   (o_bar_time),
        .o_bar_price  (o_bar_price)
    );

endmodule
